/* rtl/core/smtq_pkg.sv */
`default_nettype none

package smtq_pkg;

	// Field widths of the stream payload
	localparam int ID_W      = 6;
	localparam int TVAL_W    = 48;
	localparam int CMD_W     = 2;
	localparam int HANDLES   = 2 ** ID_W;

	// Defaults for the top-level parameters
	localparam int ENTRIES_DEF   = 64;
	localparam int TIME_BITS_DEF = 48;

	// Command codes carried in the input tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_PEEK   = 2'd2
	} cmd_t;

	// Per-cycle operation broadcast to every cell
	typedef struct packed {
		logic ins;
		logic del;
	} cell_op_t;

endpackage

`default_nettype wire

/* rtl/core/smtq_cell.sv */
`default_nettype none

module smtq_cell
	import smtq_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cell_op_t             op,
	input  wire [ID_W-1:0]       new_id,
	input  wire [TIME_BITS-1:0]  new_tval,
	input  wire                  left_valid,
	input  wire [ID_W-1:0]       left_id,
	input  wire [TIME_BITS-1:0]  left_tval,
	input  wire                  left_le,
	input  wire                  right_valid,
	input  wire [ID_W-1:0]       right_id,
	input  wire [TIME_BITS-1:0]  right_tval,
	input  wire                  pass,
	output logic                 valid,
	output logic [ID_W-1:0]      id,
	output logic [TIME_BITS-1:0] tval,
	output logic                 le,
	output logic                 hit
);

	logic                 valid_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] tval_q;

	// Entry sorts before the incoming key (ties keep insertion order)
	assign le  = valid_q && (tval_q <= new_tval);
	// Entry holds the handle being deleted
	assign hit = valid_q && (id_q == new_id);

	// Occupancy: take the new entry, shift right on insert, shift left on delete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.ins && !le) begin
			valid_q <= left_le ? 1'b1 : left_valid;
		end else if (op.del && pass) begin
			valid_q <= right_valid;
		end
	end

	// Payload follows the same moves
	always_ff @(posedge clk) begin
		if (op.ins && !le) begin
			if (left_le) begin
				id_q   <= new_id;
				tval_q <= new_tval;
			end else begin
				id_q   <= left_id;
				tval_q <= left_tval;
			end
		end else if (op.del && pass) begin
			id_q   <= right_id;
			tval_q <= right_tval;
		end
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign tval  = tval_q;

endmodule

`default_nettype wire

/* rtl/core/stable_min_timer_queue_core.sv */
// Pending-event queue over 64 handle slots, kept as a sorted row of cells.
// Input stream (s_axis_*): tuser carries the command (insert, delete, peek),
// tdata the handle and timestamp. Output stream (m_axis_*): one transaction
// per command with found, min_id, min_value and error.
// A peek returns the smallest timestamp held, earliest insertion first on
// ties, without removing it. Insert of a queued handle, delete of an absent
// handle, insert or delete of a handle of ENTRIES or more and insert into a
// full queue give error and change nothing.
// Each command is first registered while the handle flags are checked; then
// every cell shifts or loads in parallel and the result register loads. A
// new command is taken only once the one in the command register has moved
// on to the cells. When the receiver stalls, the result register holds and
// the block takes one more command, which waits in the command register
// until the result is taken. Reset empties the queue; it accepts a command
// as soon as reset is released.
`default_nettype none

module stable_min_timer_queue_core
	import smtq_pkg::*;
#(
	parameter int ENTRIES   = ENTRIES_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [55:0] s_axis_tdata,  // entry_id[5:0], time_value[53:6], zero[55:54]
	input  wire  [1:0]  s_axis_tuser,  // command[1:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata   // found[0], min_id[6:1], min_value[54:7], error[55]
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int LVLS  = $clog2(ENTRIES);

	// Command stage
	logic                 busy_q;
	cmd_t                 cmd_s1;
	logic [ID_W-1:0]      id_s1;
	logic [TIME_BITS-1:0] tval_s1;
	logic                 err_s1;

	// Queue bookkeeping
	logic [HANDLES-1:0]   queued_q;
	logic [CNT_W-1:0]     count_q;

	// Result register
	logic                 out_valid_q;
	logic [55:0]          out_data_q;

	logic                 accept;
	logic                 advance;
	cmd_t                 cmd_in;
	logic [ID_W-1:0]      id_in;
	logic [63:0]          tval_in64;
	logic                 id_ok;
	logic                 err_in;
	cell_op_t             op;
	logic [63:0]          head_tval64;
	logic                 out_hit;

	// Cell row signals
	logic                 vld   [ENTRIES];
	logic [ID_W-1:0]      cid   [ENTRIES];
	logic [TIME_BITS-1:0] ctval [ENTRIES];
	logic                 le    [ENTRIES];
	logic [ENTRIES-1:0]   hit;
	logic [ENTRIES-1:0]   pre   [LVLS+1];

	assign cmd_in    = cmd_t'(s_axis_tuser);
	assign id_in     = s_axis_tdata[5:0];
	assign tval_in64 = 64'(s_axis_tdata[53:6]);
	assign id_ok     = 32'(id_in) < ENTRIES;

	assign s_axis_tready = !busy_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign advance       = busy_q && (!out_valid_q || m_axis_tready);

	// Refuse duplicates, absent handles, out-of-range handles and a full queue
	always_comb begin
		unique case (cmd_in)
			CMD_INSERT: err_in = !id_ok || queued_q[id_in] || (count_q == CNT_W'(ENTRIES));
			CMD_DELETE: err_in = !id_ok || !queued_q[id_in];
			default:    err_in = 1'b0;
		endcase
	end

	// Hold the command until the cells take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (advance) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_in;
			id_s1   <= id_in;
			tval_s1 <= tval_in64[TIME_BITS-1:0];
			err_s1  <= err_in;
		end
	end

	// Broadcast the move to the row
	assign op.ins = advance && !err_s1 && (cmd_s1 == CMD_INSERT);
	assign op.del = advance && !err_s1 && (cmd_s1 == CMD_DELETE);

	// Track queued handles and queue length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queued_q <= '0;
			count_q  <= '0;
		end else if (op.ins) begin
			queued_q[id_s1] <= 1'b1;
			count_q         <= count_q + CNT_W'(1);
		end else if (op.del) begin
			queued_q[id_s1] <= 1'b0;
			count_q         <= count_q - CNT_W'(1);
		end
	end

	// Prefix OR of hit flags: cells at or after the deleted entry shift left
	assign pre[0] = hit;
	for (genvar l = 0; l < LVLS; l++) begin : g_lvl
		for (genvar k = 0; k < ENTRIES; k++) begin : g_bit
			if (k >= (1 << l)) begin : g_or
				assign pre[l+1][k] = pre[l][k] | pre[l][k-(1<<l)];
			end else begin : g_pass
				assign pre[l+1][k] = pre[l][k];
			end
		end
	end

	// Sorted row of cells, head at index zero
	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		logic                 l_valid;
		logic [ID_W-1:0]      l_id;
		logic [TIME_BITS-1:0] l_tval;
		logic                 l_le;
		logic                 r_valid;
		logic [ID_W-1:0]      r_id;
		logic [TIME_BITS-1:0] r_tval;

		if (k == 0) begin : g_head
			assign l_valid = 1'b0;
			assign l_id    = '0;
			assign l_tval  = '0;
			assign l_le    = 1'b1;
		end else begin : g_mid
			assign l_valid = vld[k-1];
			assign l_id    = cid[k-1];
			assign l_tval  = ctval[k-1];
			assign l_le    = le[k-1];
		end

		if (k == ENTRIES - 1) begin : g_tail
			assign r_valid = 1'b0;
			assign r_id    = '0;
			assign r_tval  = '0;
		end else begin : g_body
			assign r_valid = vld[k+1];
			assign r_id    = cid[k+1];
			assign r_tval  = ctval[k+1];
		end

		smtq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (op),
			.new_id      (id_s1),
			.new_tval    (tval_s1),
			.left_valid  (l_valid),
			.left_id     (l_id),
			.left_tval   (l_tval),
			.left_le     (l_le),
			.right_valid (r_valid),
			.right_id    (r_id),
			.right_tval  (r_tval),
			.pass        (pre[LVLS][k]),
			.valid       (vld[k]),
			.id          (cid[k]),
			.tval        (ctval[k]),
			.le          (le[k]),
			.hit         (hit[k])
		);
	end

	assign head_tval64 = 64'(ctval[0]);
	assign out_hit     = (cmd_s1 == CMD_PEEK) && vld[0];

	// Load the result; drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= out_hit ? {err_s1, head_tval64[TVAL_W-1:0], cid[0], 1'b1}
			                      : {err_s1, 55'd0};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Queue length matches the handle flags
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(queued_q) == 32'(count_q))
		else $error("queue length disagrees with queued handle flags");

	// Length never exceeds the row
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= ENTRIES)
		else $error("queue length beyond cell count");

	// Head cell is occupied exactly when the queue is not empty
	assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] == (count_q != '0))
		else $error("head cell occupancy disagrees with queue length");

	// A refused command never reports an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_data_q[0] && out_data_q[55]))
		else $error("result carries both found and error");

	// A command that advances shows up as a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q && !busy_q)
		else $error("advanced command lost");

endmodule

`default_nettype wire

/* tb/tb_stable_min_timer_queue_core.sv */
`default_nettype none

module tb_stable_min_timer_queue_core;
	timeunit 1ns;
	timeprecision 1ps;

	import smtq_pkg::*;

	localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
	localparam logic [TVAL_W-1:0] TIME_MAX   = '1;

	typedef struct {
		logic              found;
		logic [ID_W-1:0]   min_id;
		logic [TVAL_W-1:0] min_value;
		logic              error;
	} reply_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata  = '0;  // entry_id[5:0], time_value[53:6], zero[55:54]
	logic [1:0]  s_axis_tuser  = '0;  // command[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [55:0] m_axis_tdata;        // found[0], min_id[6:1], min_value[54:7], error[55]

	// Mirror of the event queue, advanced on every accepted command
	logic [TVAL_W-1:0] stamp_of [HANDLES];
	bit                is_queued [HANDLES];
	logic [ID_W-1:0]   time_order [$];

	reply_t reply_fifo [$];
	int     fail_count = 0;

	// Stimulus side view of which handles will be queued
	bit [HANDLES-1:0] occupied = '0;
	int               fill_target = 0;
	int               tx_idle_pct = 30;
	int               rx_idle_pct = 70;
	int               stall_left = 0;

	stable_min_timer_queue_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Apply one command to the mirror and return the reply it must produce
	function automatic reply_t apply_command(input logic [CMD_W-1:0] op,
			input logic [ID_W-1:0] id, input logic [TVAL_W-1:0] stamp);
		reply_t r;
		int     pos;
		r = '{default: '0};
		pos = 0;
		case (op)
			CMD_INSERT: begin
				if (is_queued[id] || time_order.size() >= HANDLES) begin
					r.error = 1'b1;
				end else begin
					// go behind every entry with a smaller or equal stamp
					while (pos < time_order.size() && stamp_of[time_order[pos]] <= stamp)
						pos++;
					time_order.insert(pos, id);
					stamp_of[id] = stamp;
					is_queued[id] = 1'b1;
				end
			end
			CMD_DELETE: begin
				if (!is_queued[id]) begin
					r.error = 1'b1;
				end else begin
					while (time_order[pos] != id)
						pos++;
					time_order.delete(pos);
					is_queued[id] = 1'b0;
				end
			end
			CMD_PEEK: begin
				if (time_order.size() > 0) begin
					r.found = 1'b1;
					r.min_id = time_order[0];
					r.min_value = stamp_of[time_order[0]];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [TVAL_W-1:0] want,
			input logic [TVAL_W-1:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	// Check each result transaction, then record each command transaction
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (reply_fifo.size() == 0) begin
				$error("result transaction with no command waiting: %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = reply_fifo.pop_front();
				compare_field("found", TVAL_W'(want.found), TVAL_W'(m_axis_tdata[0]));
				compare_field("min_id", TVAL_W'(want.min_id), TVAL_W'(m_axis_tdata[6:1]));
				compare_field("min_value", want.min_value, m_axis_tdata[54:7]);
				compare_field("error", TVAL_W'(want.error), TVAL_W'(m_axis_tdata[55]));
			end
		end
		if (arst_n && s_axis_tvalid && s_axis_tready)
			reply_fifo.push_back(apply_command(s_axis_tuser, s_axis_tdata[5:0],
				s_axis_tdata[53:6]));
	end

	// Drive tready: random idling, or a counted hold-off when requested
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	function automatic logic [TVAL_W-1:0] rand_stamp();
		logic [63:0] wide;
		wide = {$urandom(), $urandom()};
		case ($urandom_range(9)) inside
			0:       return '0;
			1:       return TIME_MAX;
			[2:5]:   return TVAL_W'($urandom_range(15));
			6:       return wide[TVAL_W-1:0];
			default: return TVAL_W'($urandom_range(999));
		endcase
	endfunction

	// Offer one command and hold it until the transaction completes
	task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] id,
			input logic [TVAL_W-1:0] stamp);
		if ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, stamp, id};
		s_axis_tuser <= op;
		if (op == CMD_INSERT)
			occupied[id] = 1'b1;
		else if (op == CMD_DELETE)
			occupied[id] = 1'b0;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
	endtask

	// Mostly valid inserts and deletes steered toward a fill level, plus noise
	task automatic random_cmd();
		int              pick;
		int              fill;
		logic [ID_W-1:0] id;
		pick = $urandom_range(99);
		fill = $countones(occupied);
		id = ID_W'($urandom_range(HANDLES - 1));
		if (pick < 4) begin
			send_cmd(CMD_UNUSED, id, rand_stamp());
		end else if (pick < 10) begin
			// refused: queued handle inserted again or free handle deleted
			if (occupied[id])
				send_cmd(CMD_INSERT, id, rand_stamp());
			else
				send_cmd(CMD_DELETE, id, rand_stamp());
		end else if (pick < 30) begin
			send_cmd(CMD_PEEK, id, rand_stamp());
		end else if ((fill < fill_target && fill < HANDLES) || fill == 0) begin
			while (occupied[id])
				id++;
			send_cmd(CMD_INSERT, id, rand_stamp());
		end else begin
			while (!occupied[id])
				id++;
			send_cmd(CMD_DELETE, id, rand_stamp());
		end
	endtask

	// Drop tvalid and wait until every result has arrived
	task automatic wait_all_replies();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (reply_fifo.size() != 0);
	endtask

	task automatic test_directed();
		send_cmd(CMD_PEEK, 6'd63, TIME_MAX);
		send_cmd(CMD_INSERT, 6'd0, TIME_MAX);
		send_cmd(CMD_PEEK, 6'd0, '0);
		send_cmd(CMD_INSERT, 6'd63, '0);
		send_cmd(CMD_PEEK, 6'd0, '0);
		// equal stamps keep insertion order
		send_cmd(CMD_INSERT, 6'd5, '0);
		send_cmd(CMD_PEEK, 6'd21, 48'h1234_5678_9abc);
		send_cmd(CMD_INSERT, 6'd63, 48'h1);
		send_cmd(CMD_DELETE, 6'd63, TIME_MAX);
		send_cmd(CMD_PEEK, 6'd0, '0);
		send_cmd(CMD_DELETE, 6'd63, '0);
		send_cmd(CMD_UNUSED, 6'd63, TIME_MAX);
		send_cmd(CMD_INSERT, 6'd42, 48'haaaa_aaaa_aaaa);
		send_cmd(CMD_INSERT, 6'd21, 48'h5555_5555_5555);
		send_cmd(CMD_PEEK, 6'd0, '0);
		send_cmd(CMD_DELETE, 6'd5, '0);
		send_cmd(CMD_PEEK, 6'd0, '0);
		send_cmd(CMD_DELETE, 6'd21, '0);
		send_cmd(CMD_PEEK, 6'd0, '0);
		send_cmd(CMD_DELETE, 6'd42, '0);
		send_cmd(CMD_DELETE, 6'd0, '0);
		send_cmd(CMD_PEEK, 6'd42, TIME_MAX);
		send_cmd(CMD_DELETE, 6'd0, '0);
	endtask

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			// move the fill level now and then, often to empty or full
			if (i % 50 == 0) begin
				case ($urandom_range(3))
					0:       fill_target = 0;
					1:       fill_target = HANDLES;
					default: fill_target = $urandom_range(HANDLES);
				endcase
			end
			random_cmd();
		end
	endtask

	// Hold the receiver off long enough that the block stalls its input
	task automatic test_output_stall();
		tx_idle_pct = 0;
		s_axis_tvalid <= 1'b0;
		@(negedge clk) stall_left = 300;
		@(posedge clk);
		for (int i = 0; i < 30; i++)
			random_cmd();
	endtask

	// Pause the sender until every result is back
	task automatic test_sender_pause();
		for (int i = 0; i < 30; i++)
			random_cmd();
		wait_all_replies();
		for (int i = 0; i < 10; i++)
			random_cmd();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(460, 30, 70);
		test_output_stall();
		test_random(460, 70, 30);
		test_sender_pause();
		test_random(460, 0, 0);
		wait_all_replies();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire
